@@ rtl/core/sxor_pkg.sv @@
`default_nettype none

package sxor_pkg;

    localparam int BLOCK_BYTES   = 64;
    localparam int WORDS         = BLOCK_BYTES / 4;
    localparam int DOUBLE_ROUNDS = 10;
    // two half quarter-round steps per round, two rounds per double round
    localparam int ROUND_STEPS   = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(ROUND_STEPS);
    localparam int POS_W         = $clog2(BLOCK_BYTES) + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_NONCE = 3'd4
    } cfg_reg_t;

    localparam logic [31:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    // word indices a, b, c, d of each quarter-round: column round, then row round
    localparam logic [3:0] QR_IDX [2][4][4] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12},
          '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},
          '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},
          '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},
          '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    typedef logic [WORDS-1:0][31:0] state_t;
    typedef logic [3:0][63:0] key_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       message_start;
    } item_t;

    typedef struct packed {
        logic take;
        logic restart;
    } gen_ctl_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic state_t make_init(input key_t key, input logic [63:0] nonce,
                                         input logic [63:0] ctr);
        state_t s;
        s[0]  = SIGMA[0];
        s[1]  = key[0][31:0];
        s[2]  = key[0][63:32];
        s[3]  = key[1][31:0];
        s[4]  = key[1][63:32];
        s[5]  = SIGMA[1];
        s[6]  = nonce[31:0];
        s[7]  = nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA[2];
        s[11] = key[2][31:0];
        s[12] = key[2][63:32];
        s[13] = key[3][31:0];
        s[14] = key[3][63:32];
        s[15] = SIGMA[3];
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sxor_in_if.sv @@
`default_nettype none

interface sxor_in_if import sxor_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       message_start;

    modport source (output valid, output data_in, output message_start, input ready);
    modport sink   (input valid, input data_in, input message_start, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sxor_out_if.sv @@
`default_nettype none

interface sxor_out_if import sxor_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sxor_cfg_if.sv @@
`default_nettype none

interface sxor_cfg_if import sxor_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sxor_front.sv @@
`default_nettype none

module sxor_front import sxor_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sxor_in_if.sink    item,
    output logic       head_valid,
    output item_t      head,
    input  wire logic  pop
);

    item_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                accept;

    assign item.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign accept     = item.valid & item.ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({accept, pop})
            2'b10:   count_next = count_reg + (QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= '{data_in: item.data_in, message_start: item.message_start};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sxor_core.sv @@
`default_nettype none

module sxor_core import sxor_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire key_t         key,
    input  wire logic [63:0]  nonce,
    input  wire logic         cfg_wr,
    input  wire gen_ctl_t     ctl,
    output logic              blk_valid,
    output state_t            blk
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FINAL = 3'b100
    } core_state_t;

    core_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [63:0]         ctr_reg, ctr_next;
    logic                blk_valid_reg, blk_valid_next;
    state_t              work_reg, work_next;
    state_t              blk_reg, blk_next;
    state_t              init;
    state_t              round_out;
    state_t              alt [2];
    logic [31:0]         nb, nc, nd, na;
    logic [3:0]          ia, ib, ic, id;

    // ctr_reg is the block the buffer loads next; it holds while a block is computed
    assign init      = make_init(key, nonce, ctr_reg);
    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;

    // half a quarter-round on all four quarter-rounds at once: two add-rotate-xor
    always_comb
    begin
        nb = '0;
        nc = '0;
        nd = '0;
        na = '0;
        ia = '0;
        ib = '0;
        ic = '0;
        id = '0;
        for (int t = 0; t < 2; t++)
        begin
            alt[t] = work_reg;
            for (int q = 0; q < 4; q++)
            begin
                ia = QR_IDX[t][q][0];
                ib = QR_IDX[t][q][1];
                ic = QR_IDX[t][q][2];
                id = QR_IDX[t][q][3];
                if (!step_reg[0])
                begin
                    nb = work_reg[ib] ^ rotl32(work_reg[ia] + work_reg[id], 7);
                    nc = work_reg[ic] ^ rotl32(nb + work_reg[ia], 9);
                    alt[t][ib] = nb;
                    alt[t][ic] = nc;
                end
                else
                begin
                    nd = work_reg[id] ^ rotl32(work_reg[ic] + work_reg[ib], 13);
                    na = work_reg[ia] ^ rotl32(nd + work_reg[ic], 18);
                    alt[t][id] = nd;
                    alt[t][ia] = na;
                end
            end
        end
        // odd rounds are row rounds
        round_out = step_reg[1] ? alt[1] : alt[0];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ctr_next       = ctr_reg;
        blk_valid_next = blk_valid_reg;
        work_next      = work_reg;
        blk_next       = blk_reg;
        if (ctl.restart)
        begin
            state_next     = ST_IDLE;
            blk_valid_next = 1'b0;
            ctr_next       = '0;
        end
        else if (cfg_wr)
        begin
            // drop the prefetched block: it used the old key or nonce
            state_next     = ST_IDLE;
            blk_valid_next = 1'b0;
        end
        else
        begin
            if (ctl.take)
            begin
                blk_valid_next = 1'b0;
                ctr_next       = ctr_reg + 64'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!blk_valid_reg)
                    begin
                        work_next  = init;
                        step_next  = '0;
                        state_next = ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    work_next = round_out;
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ROUND_STEPS - 1))
                    begin
                        state_next = ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    for (int i = 0; i < WORDS; i++)
                    begin
                        blk_next[i] = work_reg[i] + init[i];
                    end
                    blk_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ctr_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ctr_reg       <= ctr_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        blk_reg  <= blk_next;
    end

    a_blk_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg |-> state_reg == ST_IDLE)
        else $error("next block marked valid while the round engine runs");

    a_ctr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && !ctl.restart && !cfg_wr |=> ctr_reg == $past(ctr_reg) + 64'd1)
        else $error("block counter did not advance on block load");

endmodule

`default_nettype wire

@@ rtl/core/sxor_back.sv @@
`default_nettype none

module sxor_back import sxor_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    head_valid,
    input  wire item_t   head,
    output logic         pop,
    input  wire logic    blk_valid,
    input  wire state_t  blk,
    output gen_ctl_t     ctl,
    sxor_out_if.source   result
);

    state_t             buf_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               start_done_reg;
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;
    logic               eff_start;
    logic               out_free;
    logic               have_ks;
    state_t             src;
    logic [31:0]        ks_word;
    logic [7:0]         ks_byte;

    // start flag of the head transaction counts once, then the item runs as a normal byte
    assign eff_start   = head.message_start & ~start_done_reg;
    assign out_free    = ~out_valid_reg | result.ready;
    assign have_ks     = ~pos_reg[POS_W-1] | blk_valid;
    assign ctl.restart = head_valid & eff_start;
    assign pop         = head_valid & ~eff_start & have_ks & out_free;
    assign ctl.take    = pop & pos_reg[POS_W-1];

    // empty buffer: read the first byte straight from the next block
    assign src     = pos_reg[POS_W-1] ? blk : buf_reg;
    assign ks_word = src[pos_reg[POS_W-2:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    assign result.valid    = out_valid_reg;
    assign result.data_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_W'(BLOCK_BYTES);
            start_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.restart)
            begin
                pos_reg        <= POS_W'(BLOCK_BYTES);
                start_done_reg <= 1'b1;
            end
            else if (pop)
            begin
                start_done_reg <= 1'b0;
                pos_reg        <= ctl.take ? POS_W'(1) : pos_reg + POS_W'(1);
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            buf_reg <= blk;
        end
        if (pop)
        begin
            out_data_reg <= head.data_in ^ ks_byte;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(BLOCK_BYTES))
        else $error("byte position beyond block");

    a_take_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> blk_valid)
        else $error("buffer loaded without a finished block");

    a_restart_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.restart |=> pos_reg == POS_W'(BLOCK_BYTES) && start_done_reg)
        else $error("message start did not empty the keystream buffer");

endmodule

`default_nettype wire

@@ rtl/core/salsa20_stream_xor.sv @@
// Salsa20/20 stream cipher: each input transaction carries one byte, and one output
// transaction returns that byte XORed with the next keystream byte. message_start
// restarts the stream at block counter 0 before its byte. Key (four 64-bit words) and
// nonce are to be written through the configuration channel only while the stream is
// idle; the block does not enforce this. A write discards any block computed ahead.
// The round engine does half a quarter-round on all four quarter-rounds each cycle;
// a 64-byte block (start, 40 round steps, feed-forward add) is computed while the
// previous block is consumed, so one byte per cycle is sustained while input bytes
// arrive and output is not held back. The first byte after reset or message_start
// waits for block 0, and a configuration write restarts the pending block; each
// result then appears in the cycle after its byte leaves the two-entry input queue.
`default_nettype none

module salsa20_stream_xor import sxor_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sxor_in_if.sink      item,
    sxor_out_if.source   result,
    sxor_cfg_if.sink     cfg
);

    key_t         key_reg;
    logic [63:0]  nonce_reg;
    logic         cfg_wr;
    logic         head_valid;
    item_t        head;
    logic         pop;
    logic         blk_valid;
    state_t       blk;
    gen_ctl_t     ctl;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                REG_KEY0:  key_reg[0] <= cfg.data;
                REG_KEY1:  key_reg[1] <= cfg.data;
                REG_KEY2:  key_reg[2] <= cfg.data;
                REG_KEY3:  key_reg[3] <= cfg.data;
                REG_NONCE: nonce_reg  <= cfg.data;
                default:   ;
            endcase
        end
    end

    sxor_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sxor_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .nonce     (nonce_reg),
        .cfg_wr    (cfg_wr),
        .ctl       (ctl),
        .blk_valid (blk_valid),
        .blk       (blk)
    );

    sxor_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .blk_valid  (blk_valid),
        .blk        (blk),
        .ctl        (ctl),
        .result     (result)
    );

endmodule

`default_nettype wire
